@@ hw/rtl/pcpc_pkg.sv @@
// ============================================================================
// pcpc_pkg
// Shared types and codes for the pyro channel pulse controller.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pcpc_pkg;

  localparam int REQ_W  = 3;
  localparam int CHAN_W = 2;
  localparam int TIME_W = 32;
  localparam int ST_W   = 2;
  localparam int PIN_W  = 4;
  localparam int TOT_W  = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FIRE     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FIRE_ALL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLR      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLR_ALL  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_ARG   = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_STATE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } pcpc_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic commit;   // update channel state and load the result register
  } pcpc_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/pcpc_ctrl.sv @@
// ============================================================================
// pcpc_ctrl
// Handshake sequencer: takes a word, runs one execute step, owns out_valid.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pcpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pcpc_pkg::pcpc_cmd_t cmd
);
  import pcpc_pkg::*;

  pcpc_state_t state, state_next;
  logic        out_valid_next;
  logic        slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait until the result register can take the new word
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pcpc_datapath.sv @@
// ============================================================================
// pcpc_datapath
// Channel state, per-channel countdowns, command decode and result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pcpc_datapath #(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pcpc_pkg::pcpc_cmd_t           cmd,
  input  logic [pcpc_pkg::REQ_W-1:0]    req_type,
  input  logic [pcpc_pkg::CHAN_W-1:0]   channel,
  input  logic [pcpc_pkg::TIME_W-1:0]   pulse_ms,
  output logic [pcpc_pkg::ST_W-1:0]     status_code,
  output logic [pcpc_pkg::PIN_W-1:0]    pin_levels,
  output logic [pcpc_pkg::PIN_W-1:0]    fired_mask,
  output logic [pcpc_pkg::TOT_W-1:0]    fired_total,
  output logic                          chan_fired,
  output logic [pcpc_pkg::TIME_W-1:0]   chan_stamp,
  output logic [pcpc_pkg::TIME_W-1:0]   chan_duration
);
  import pcpc_pkg::*;

  localparam int CNT_RAW = $clog2(CHANNEL_COUNT + 1);
  localparam int CNT_W   = (CNT_RAW > TOT_W) ? CNT_RAW : TOT_W;

  // captured word
  logic [REQ_W-1:0]  req_q;
  logic [CHAN_W-1:0] chan_q;
  logic [TIME_W-1:0] dur_q;

  // channel state
  logic [TIME_W-1:0]        now_ms, now_ms_next;
  logic [CHANNEL_COUNT-1:0] latch, latch_next;
  logic [CHANNEL_COUNT-1:0] level, level_next;
  logic [TIME_W-1:0]        stamp [CHANNEL_COUNT];
  logic [TIME_W-1:0]        stamp_next [CHANNEL_COUNT];
  logic [TIME_W-1:0]        plen [CHANNEL_COUNT];
  logic [TIME_W-1:0]        plen_next [CHANNEL_COUNT];
  logic [TIME_W-1:0]        remain [CHANNEL_COUNT];
  logic [TIME_W-1:0]        remain_next [CHANNEL_COUNT];

  // decode helpers
  logic [CHANNEL_COUNT-1:0] sel;
  logic                     chan_hit;
  logic                     dur_zero;

  // result word
  logic [ST_W-1:0]   status;
  logic [PIN_W-1:0]  pins;
  logic [PIN_W-1:0]  mask;
  logic [CNT_W-1:0]  total;
  logic              cf;
  logic [TIME_W-1:0] ct;
  logic [TIME_W-1:0] cd;

  assign chan_hit = (32'(chan_q) < CHANNEL_COUNT);
  assign dur_zero = (dur_q == '0);

  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      sel[c] = (32'(chan_q) == c);
    end
  end

  always_comb begin
    now_ms_next = now_ms;
    latch_next  = latch;
    level_next  = level;
    stamp_next  = stamp;
    plen_next   = plen;
    remain_next = remain;
    status      = ST_OK;
    case (req_q)
      REQ_TICK: begin
        now_ms_next = now_ms + 1'b1;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
          if (remain[c] != '0) begin
            remain_next[c] = remain[c] - 1'b1;
            if (remain[c] == TIME_W'(1)) begin
              level_next[c] = 1'b0;
            end
          end
        end
      end
      REQ_FIRE: begin
        if (!chan_hit || dur_zero) begin
          status = ST_BAD_ARG;
        end else begin
          for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (sel[c]) begin
              if (latch[c]) begin
                status = ST_BAD_STATE;
              end else begin
                level_next[c]  = 1'b1;
                latch_next[c]  = 1'b1;
                stamp_next[c]  = now_ms;
                plen_next[c]   = dur_q;
                remain_next[c] = dur_q;
              end
            end
          end
        end
      end
      REQ_FIRE_ALL: begin
        // every channel tried; status left by the highest channel
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
          if (dur_zero) begin
            status = ST_BAD_ARG;
          end else if (latch[c]) begin
            status = ST_BAD_STATE;
          end else begin
            status         = ST_OK;
            level_next[c]  = 1'b1;
            latch_next[c]  = 1'b1;
            stamp_next[c]  = now_ms;
            plen_next[c]   = dur_q;
            remain_next[c] = dur_q;
          end
        end
      end
      REQ_CLR: begin
        if (!chan_hit) begin
          status = ST_BAD_ARG;
        end else begin
          for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (sel[c]) begin
              level_next[c]  = 1'b0;
              latch_next[c]  = 1'b0;
              stamp_next[c]  = '0;
              plen_next[c]   = '0;
              remain_next[c] = '0;
            end
          end
        end
      end
      REQ_CLR_ALL: begin
        latch_next = '0;
        level_next = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
          stamp_next[c]  = '0;
          plen_next[c]   = '0;
          remain_next[c] = '0;
        end
      end
      default: ;  // unknown request: no change
    endcase
  end

  // result taken from the state after the word
  always_comb begin
    pins  = '0;
    mask  = '0;
    total = '0;
    cf    = 1'b0;
    ct    = '0;
    cd    = '0;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      if (c < PIN_W) begin
        pins[c] = level_next[c];
        mask[c] = latch_next[c];
      end
      total = total + CNT_W'(latch_next[c]);
      if (sel[c]) begin
        cf = latch_next[c];
        ct = stamp_next[c];
        cd = plen_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_type;
      chan_q <= channel;
      dur_q  <= pulse_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
      latch  <= '0;
      level  <= '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        stamp[c]  <= '0;
        plen[c]   <= '0;
        remain[c] <= '0;
      end
    end else if (cmd.commit) begin
      now_ms <= now_ms_next;
      latch  <= latch_next;
      level  <= level_next;
      stamp  <= stamp_next;
      plen   <= plen_next;
      remain <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_code    <= status;
      pin_levels     <= pins;
      fired_mask     <= mask;
      fired_total    <= total[TOT_W-1:0];
      chan_fired     <= cf;
      chan_stamp     <= ct;
      chan_duration  <= cd;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pyro_channel_pulse_controller_unit.sv @@
// ============================================================================
// pyro_channel_pulse_controller_unit
// Multichannel one-shot pulse timer for pyro outputs: 1 ms ticks and
// fire / reset commands in, one status word out per input word.
// ============================================================================
//
//  channel | signals                                    | word
//  --------+--------------------------------------------+--------------------------
//  in      | in_valid, in_ready                         | req_type, channel,
//          |                                            | pulse_ms
//  out     | out_valid, out_ready                       | status_code, pin_levels,
//          |                                            | fired_mask, fired_total,
//          |                                            | chan_fired, chan_stamp,
//          |                                            | chan_duration
//
// An input word is accepted, then run in one execute step in which all
// channel countdowns update in parallel and the result register loads.
// A new word is accepted in the cycle after the execute step, so the
// block takes no new word while the last one is still in its execute step.
// A result waiting in the output register does not block the next accept;
// the execute step holds until that register is free.
// Synchronous reset clears all channels, the ms counter and out_valid.
`timescale 1ns / 1ps
`default_nettype none

module pyro_channel_pulse_controller_unit #(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pcpc_pkg::REQ_W-1:0]    req_type,
  input  logic [pcpc_pkg::CHAN_W-1:0]   channel,
  input  logic [pcpc_pkg::TIME_W-1:0]   pulse_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcpc_pkg::ST_W-1:0]     status_code,
  output logic [pcpc_pkg::PIN_W-1:0]    pin_levels,
  output logic [pcpc_pkg::PIN_W-1:0]    fired_mask,
  output logic [pcpc_pkg::TOT_W-1:0]    fired_total,
  output logic                          chan_fired,
  output logic [pcpc_pkg::TIME_W-1:0]   chan_stamp,
  output logic [pcpc_pkg::TIME_W-1:0]   chan_duration
);
  import pcpc_pkg::*;

  pcpc_cmd_t cmd;

  pcpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pcpc_datapath #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_type       (req_type),
    .channel        (channel),
    .pulse_ms       (pulse_ms),
    .status_code    (status_code),
    .pin_levels     (pin_levels),
    .fired_mask     (fired_mask),
    .fired_total    (fired_total),
    .chan_fired     (chan_fired),
    .chan_stamp     (chan_stamp),
    .chan_duration  (chan_duration)
  );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Bench for the pyro channel pulse controller. A short table of directed
// words covers fire, fire-all, reset, reset-all, ticks, zero durations,
// refires and unused request codes. A long random run follows. Every result
// word is checked field by field against a typed-in word (some directed rows)
// or an in-bench model of the four channel timers. Handshakes see random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pcpc_pkg::*;

  localparam int NCH          = 4;
  localparam int DIRECTED_LEN = 21;
  localparam int RANDOM_WORDS = 800;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [PIN_W-1:0]  pins;
    logic [PIN_W-1:0]  mask;
    logic [TOT_W-1:0]  total;
    logic              fired;
    logic [TIME_W-1:0] stamp_ms;
    logic [TIME_W-1:0] duration;
  } pulse_report_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [CHAN_W-1:0] ch;
    logic [TIME_W-1:0] dur;
    logic              known;
    pulse_report_t     rep;
  } directed_row_t;

  localparam pulse_report_t NO_REPORT = '0;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type = REQ_TICK;
  logic [CHAN_W-1:0] channel = '0;
  logic [TIME_W-1:0] pulse_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ST_W-1:0]   status_code;
  logic [PIN_W-1:0]  pin_levels;
  logic [PIN_W-1:0]  fired_mask;
  logic [TOT_W-1:0]  fired_total;
  logic              chan_fired;
  logic [TIME_W-1:0] chan_stamp;
  logic [TIME_W-1:0] chan_duration;

  pyro_channel_pulse_controller_unit #(.CHANNEL_COUNT(NCH)) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .channel        (channel),
    .pulse_ms       (pulse_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status_code    (status_code),
    .pin_levels     (pin_levels),
    .fired_mask     (fired_mask),
    .fired_total    (fired_total),
    .chan_fired     (chan_fired),
    .chan_stamp     (chan_stamp),
    .chan_duration  (chan_duration)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // timer model state
  logic [TIME_W-1:0] clock_ms;
  logic [NCH-1:0]    latched;
  logic [NCH-1:0]    level;
  logic [TIME_W-1:0] stamp [NCH];
  logic [TIME_W-1:0] plen [NCH];
  logic [TIME_W-1:0] left_ms [NCH];

  pulse_report_t expected_reports [$];
  directed_row_t directed_rows [DIRECTED_LEN];
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            stall_left = 0;
  logic          steady = 1'b0;

  function automatic void clear_chan(int c);
    latched[c] = 1'b0;
    level[c]   = 1'b0;
    stamp[c]   = '0;
    plen[c]    = '0;
    left_ms[c] = '0;
  endfunction

  function automatic logic [ST_W-1:0] try_fire(int c, logic [TIME_W-1:0] d);
    if (c >= NCH || d == '0) return ST_BAD_ARG;
    if (latched[c]) return ST_BAD_STATE;
    latched[c] = 1'b1;
    level[c]   = 1'b1;
    stamp[c]   = clock_ms;
    plen[c]    = d;
    left_ms[c] = d;
    return ST_OK;
  endfunction

  function automatic pulse_report_t pulse_step(logic [REQ_W-1:0] req, logic [CHAN_W-1:0] ch,
                                               logic [TIME_W-1:0] d);
    pulse_report_t r;
    logic [ST_W-1:0] st;
    st = ST_OK;
    case (req)
      REQ_TICK: begin
        clock_ms = clock_ms + 1;
        for (int c = 0; c < NCH; c++) begin
          if (left_ms[c] != '0) begin
            left_ms[c] = left_ms[c] - 1;
            if (left_ms[c] == '0) level[c] = 1'b0;
          end
        end
      end
      REQ_FIRE: st = try_fire(int'(ch), d);
      REQ_FIRE_ALL: begin
        // status of the last channel tried wins
        for (int c = 0; c < NCH; c++) st = try_fire(c, d);
      end
      REQ_CLR: begin
        if (int'(ch) < NCH) clear_chan(int'(ch));
        else st = ST_BAD_ARG;
      end
      REQ_CLR_ALL: begin
        for (int c = 0; c < NCH; c++) clear_chan(c);
      end
      default: ;
    endcase
    r = '0;
    r.status = st;
    for (int c = 0; c < NCH; c++) begin
      r.pins[c] = level[c];
      r.mask[c] = latched[c];
      if (latched[c]) r.total = r.total + 1'b1;
    end
    if (int'(ch) < NCH) begin
      r.fired     = latched[ch];
      r.stamp_ms  = stamp[ch];
      r.duration  = plen[ch];
    end
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_word(input logic [REQ_W-1:0] req, input logic [CHAN_W-1:0] ch,
                           input logic [TIME_W-1:0] d, input logic known,
                           input pulse_report_t typed);
    int gap;
    pulse_report_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    channel     <= ch;
    pulse_ms    <= d;
    do @(posedge clk); while (!in_ready);
    predicted = pulse_step(req, ch, d);
    expected_reports.push_back(known ? typed : predicted);
  endtask

  task automatic send_random_word();
    int r;
    logic [REQ_W-1:0] req;
    logic [TIME_W-1:0] d;
    r = $urandom_range(0, 99);
    if (r < 45) req = REQ_TICK;
    else if (r < 65) req = REQ_FIRE;
    else if (r < 72) req = REQ_FIRE_ALL;
    else if (r < 85) req = REQ_CLR;
    else if (r < 92) req = REQ_CLR_ALL;
    else if (r < 95) req = REQ_RSVD_5;
    else if (r < 98) req = REQ_RSVD_6;
    else req = REQ_RSVD_7;
    // short pulses so outputs drop within the run; a few full-width ones
    r = $urandom_range(0, 99);
    if (req != REQ_FIRE && req != REQ_FIRE_ALL) d = $urandom();
    else if (r < 5) d = '0;
    else if (r < 85) d = $urandom_range(1, 12);
    else if (r < 95) d = $urandom_range(13, 200);
    else d = $urandom();
    send_word(req, CHAN_W'($urandom_range(0, NCH - 1)), d, 1'b0, NO_REPORT);
  endtask

  task automatic report_field(input string field, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected %0h, got %0h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    pulse_report_t got;
    pulse_report_t want;
    if (!rst && out_valid && out_ready) begin
      got = {status_code, pin_levels, fired_mask, fired_total, chan_fired,
             chan_stamp, chan_duration};
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t result word with none expected", $realtime);
      end else begin
        want = expected_reports.pop_front();
        report_field("status_code", TIME_W'(want.status), TIME_W'(got.status));
        report_field("pin_levels", TIME_W'(want.pins), TIME_W'(got.pins));
        report_field("fired_mask", TIME_W'(want.mask), TIME_W'(got.mask));
        report_field("fired_total", TIME_W'(want.total), TIME_W'(got.total));
        report_field("chan_fired", TIME_W'(want.fired), TIME_W'(got.fired));
        report_field("chan_stamp", want.stamp_ms, got.stamp_ms);
        report_field("chan_duration", want.duration, got.duration);
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    clock_ms = '0;
    for (int c = 0; c < NCH; c++) clear_chan(c);

    // req, channel, duration, typed-in flag, expected word
    directed_rows[0]  = {REQ_TICK, 2'd0, 32'd0, 1'b1, NO_REPORT};
    directed_rows[1]  = {REQ_FIRE, 2'd0, 32'd0, 1'b1,
                         ST_BAD_ARG, 4'h0, 4'h0, 3'd0, 1'b0, 32'd0, 32'd0};
    directed_rows[2]  = {REQ_FIRE, 2'd1, 32'hFFFF_FFFF, 1'b1,
                         ST_OK, 4'b0010, 4'b0010, 3'd1, 1'b1, 32'd1, 32'hFFFF_FFFF};
    directed_rows[3]  = {REQ_FIRE, 2'd1, 32'd5, 1'b1,
                         ST_BAD_STATE, 4'b0010, 4'b0010, 3'd1, 1'b1, 32'd1, 32'hFFFF_FFFF};
    directed_rows[4]  = {REQ_FIRE, 2'd0, 32'd1, 1'b0, NO_REPORT};
    directed_rows[5]  = {REQ_TICK, 2'd0, 32'd0, 1'b0, NO_REPORT};
    directed_rows[6]  = {REQ_FIRE_ALL, 2'd2, 32'd2, 1'b0, NO_REPORT};
    directed_rows[7]  = {REQ_FIRE_ALL, 2'd3, 32'd0, 1'b0, NO_REPORT};
    directed_rows[8]  = {REQ_FIRE_ALL, 2'd0, 32'd3, 1'b0, NO_REPORT};
    directed_rows[9]  = {REQ_TICK, 2'd2, 32'd0, 1'b0, NO_REPORT};
    directed_rows[10] = {REQ_TICK, 2'd2, 32'hFFFF_FFFF, 1'b0, NO_REPORT};
    directed_rows[11] = {REQ_RSVD_5, 2'd1, 32'hAAAA_AAAA, 1'b0, NO_REPORT};
    directed_rows[12] = {REQ_RSVD_6, 2'd2, 32'h5555_5555, 1'b0, NO_REPORT};
    directed_rows[13] = {REQ_RSVD_7, 2'd3, 32'hFFFF_FFFF, 1'b0, NO_REPORT};
    directed_rows[14] = {REQ_CLR, 2'd1, 32'd0, 1'b0, NO_REPORT};
    directed_rows[15] = {REQ_CLR, 2'd3, 32'd7, 1'b0, NO_REPORT};
    directed_rows[16] = {REQ_CLR_ALL, 2'd0, 32'd0, 1'b1, NO_REPORT};
    directed_rows[17] = {REQ_FIRE, 2'd3, 32'h8000_0000, 1'b0, NO_REPORT};
    directed_rows[18] = {REQ_FIRE, 2'd2, 32'd1, 1'b0, NO_REPORT};
    directed_rows[19] = {REQ_TICK, 2'd2, 32'd0, 1'b0, NO_REPORT};
    directed_rows[20] = {REQ_CLR_ALL, 2'd3, 32'hFFFF_FFFF, 1'b1, NO_REPORT};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++)
      send_word(directed_rows[i].req, directed_rows[i].ch, directed_rows[i].dur,
                directed_rows[i].known, directed_rows[i].rep);

    // second quarter runs back to back on both sides
    for (int phase = 0; phase < 4; phase++) begin
      steady = (phase == 1);
      for (int i = 0; i < RANDOM_WORDS / 4; i++) send_random_word();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
